@@ rtl/core/two_level_page_walk_mmu_assert.svh @@
// Assertion macros for the page walk MMU.
// TLPW_ASSERT_IMPLY: antecedent and consequent in the same cycle.
// TLPW_ASSERT_NEXT:  consequent in the cycle after the antecedent.
`ifndef TWO_LEVEL_PAGE_WALK_MMU_ASSERT_SVH
`define TWO_LEVEL_PAGE_WALK_MMU_ASSERT_SVH

`ifndef SYNTHESIS
`define TLPW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlpw assertion failed");
`define TLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlpw assertion failed");
`else
`define TLPW_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/tlpw_pkg.sv @@
`timescale 1ns / 1ps

package tlpw_pkg;

    localparam int PHYS_ADDR_BITS_DEF = 16;

    // Page geometry
    localparam int PAGE_OFF_BITS = 12;
    localparam int DIR_SHIFT     = 22;
    localparam int MAX_LEN       = 4;

    // Entry bits
    localparam int BIT_PRESENT  = 0;
    localparam int BIT_ACCESSED = 5;
    localparam int BIT_DIRTY    = 6;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGING_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_DIR  = 2'd1;

    typedef enum logic [1:0] {
        FLT_OK    = 2'd0,
        FLT_DIR   = 2'd1,
        FLT_TAB   = 2'd2,
        FLT_RANGE = 2'd3
    } t_fault;

endpackage

@@ rtl/core/two_level_page_walk_mmu.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+----------------------
// command   | in        | start & !busy                | i_cmd, i_vaddr,
//           |           |                              | i_access_len, i_write_data
// result    | out       | o_valid, one-cycle strobe    | o_read_data, o_fault_code
// config    | in        | i_cfg_valid & o_cfg_ready    | i_cfg_index, i_cfg_data
//
// All work goes through the single byte port of the physical memory,
// addressed by one base + offset adder under the sequencer. Each part runs a
// setup step; with paging on, a walk that reads the directory entry,
// writes it back (only if accessed was clear), reads the table entry and
// writes it back; then a byte loop. A final step posts the result.
// An access that crosses a page is split into two parts, each walked on
// its own. busy is high from the transfer until the result.
// Reset: synchronous, active low; clears the sequencer, result strobe and
// config registers. Memory contents are not cleared (undefined until written).
// The result receiver cannot stall; a result is on the ports for one cycle.
// ---------------------------------------------------------------------------
`include "two_level_page_walk_mmu_assert.svh"

module two_level_page_walk_mmu #(
    parameter int PHYS_ADDR_BITS = tlpw_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command transfer
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cmd,
    input  logic [31:0]                    i_vaddr,
    input  logic [2:0]                     i_access_len,
    input  logic [31:0]                    i_write_data,
    // result strobe
    output logic                           o_valid,
    output logic [31:0]                    o_read_data,
    output logic [1:0]                     o_fault_code,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tlpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    import tlpw_pkg::*;

    localparam int MEM_BYTES = 1 << PHYS_ADDR_BITS;
    localparam int PAB       = PHYS_ADDR_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PART   = 8'b0000_0010,  // split off the next part, start the walk or the byte loop
        S_DIR_RD = 8'b0000_0100,  // read directory entry bytes
        S_DIR_WB = 8'b0000_1000,  // set accessed in directory entry
        S_TAB_RD = 8'b0001_0000,  // read table entry bytes
        S_TAB_WB = 8'b0010_0000,  // set accessed/dirty in table entry
        S_DATA   = 8'b0100_0000,  // byte loop over the part
        S_FIN    = 8'b1000_0000   // post the result
    } t_state;

    // sequencer and item registers
    t_state          r_state,     n_state;
    logic            r_cmd,       n_cmd;
    logic [31:0]     r_va,        n_va;
    logic [2:0]      r_len,       n_len;
    logic [31:0]     r_wdata,     n_wdata;
    logic [2:0]      r_done,      n_done;
    logic [2:0]      r_chunk,     n_chunk;
    logic [2:0]      r_cnt,       n_cnt;
    logic [31:0]     r_cur,       n_cur;
    logic [31:0]     r_ent,       n_ent;
    logic [PAB-1:0]  r_base,      n_base;
    logic [31:0]     r_rdata,     n_rdata;
    t_fault          r_fault,     n_fault;
    // result registers
    logic            r_valid,     n_valid;
    logic [31:0]     r_read_data, n_read_data;
    t_fault          r_fault_code, n_fault_code;
    // config registers
    logic            r_pg;
    logic [31:0]     r_pdb;

    // memory port
    logic [7:0]      mem [0:MEM_BYTES-1];
    logic [7:0]      r_mem_q;
    logic [PAB-1:0]  mem_addr;
    logic [1:0]      mem_off;
    logic            mem_we;
    logic [7:0]      mem_wdata;

    // datapath helpers
    logic [2:0]      len_sat;
    logic [31:0]     cur;
    logic [2:0]      remaining;
    logic [12:0]     page_left;
    logic [2:0]      chunk;
    logic [31:0]     dir_addr;
    logic [31:0]     ent_now;
    logic [31:0]     ent_sel;
    logic [31:0]     tab_addr;
    logic [31:0]     phys_addr;
    logic [1:0]      byte_idx;
    logic [1:0]      wpos;
    logic [1:0]      rpos;
    logic [2:0]      done_sum;
    logic            cfg_we;

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_read_data  = r_read_data;
    assign o_fault_code = r_fault_code;
    assign o_cfg_ready  = 1'b1;
    assign cfg_we       = i_cfg_valid && o_cfg_ready;

    // ---- shared address unit: base + small offset ----
    assign mem_off  = (r_state == S_DIR_WB || r_state == S_TAB_WB) ? 2'd0 : r_cnt[1:0];
    assign mem_addr = r_base + PAB'(mem_off);

    // ---- part split ----
    assign len_sat   = (i_access_len > 3'(MAX_LEN)) ? 3'(MAX_LEN) : i_access_len;
    assign cur       = r_va + 32'(r_done);
    assign remaining = r_len - r_done;
    assign page_left = 13'h1000 - {1'b0, cur[PAGE_OFF_BITS-1:0]};
    assign chunk     = (page_left < 13'(remaining)) ? page_left[2:0] : remaining;

    // ---- walk addresses; entries and directory are word aligned ----
    assign dir_addr  = {r_pdb[31:PAGE_OFF_BITS], cur[31:DIR_SHIFT], 2'b00};
    assign ent_now   = {r_mem_q, r_ent[23:0]};
    assign ent_sel   = (r_state == S_DIR_RD) ? ent_now : r_ent;
    assign tab_addr  = {ent_sel[31:PAGE_OFF_BITS], r_cur[DIR_SHIFT-1:PAGE_OFF_BITS], 2'b00};
    assign phys_addr = {r_ent[31:PAGE_OFF_BITS], r_cur[PAGE_OFF_BITS-1:0]};

    // byte lanes
    assign byte_idx = r_cnt[1:0] - 2'd1;
    assign wpos     = r_done[1:0] + r_cnt[1:0];
    assign rpos     = wpos - 2'd1;
    assign done_sum = r_done + r_chunk;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_wdata[{wpos, 3'b000} +: 8];
        case (r_state)
            S_DIR_WB: begin
                mem_we    = 1'b1;
                mem_wdata = r_ent[7:0] | 8'(1 << BIT_ACCESSED);
            end
            S_TAB_WB: begin
                mem_we    = 1'b1;
                mem_wdata = r_ent[7:0] | 8'(1 << BIT_ACCESSED)
                          | (r_cmd ? 8'(1 << BIT_DIRTY) : 8'd0);
            end
            S_DATA: begin
                mem_we = r_cmd && (r_cnt != r_chunk);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ---- sequencer ----
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_va         = r_va;
        n_len        = r_len;
        n_wdata      = r_wdata;
        n_done       = r_done;
        n_chunk      = r_chunk;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_ent        = r_ent;
        n_base       = r_base;
        n_rdata      = r_rdata;
        n_fault      = r_fault;
        n_valid      = 1'b0;
        n_read_data  = r_read_data;
        n_fault_code = r_fault_code;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_va    = i_vaddr;
                    n_len   = len_sat;
                    n_wdata = i_write_data;
                    n_done  = 3'd0;
                    n_rdata = 32'd0;
                    n_fault = FLT_OK;
                    // zero length: nothing to touch
                    n_state = (len_sat == 3'd0) ? S_FIN : S_PART;
                end
            end

            S_PART: begin
                n_cur   = cur;
                n_chunk = chunk;
                n_cnt   = 3'd0;
                if (r_pg) begin
                    if (dir_addr[31:PAB] != '0) begin
                        n_fault = FLT_RANGE;
                        n_state = S_FIN;
                    end else begin
                        n_base  = dir_addr[PAB-1:0];
                        n_state = S_DIR_RD;
                    end
                end else begin
                    // identity map; a part never crosses a page, so the
                    // upper bits alone decide the range check
                    if (cur[31:PAB] != '0) begin
                        n_fault = FLT_RANGE;
                        n_state = S_FIN;
                    end else begin
                        n_base  = cur[PAB-1:0];
                        n_state = S_DATA;
                    end
                end
            end

            S_DIR_RD, S_TAB_RD: begin
                // read data is registered and arrives in the cycle after its address
                n_cnt = r_cnt + 3'd1;
                if (r_cnt != 3'd0) begin
                    n_ent[{byte_idx, 3'b000} +: 8] = r_mem_q;
                end
                if (r_cnt == 3'd4) begin
                    n_cnt = 3'd0;
                    if (!ent_now[BIT_PRESENT]) begin
                        n_fault = (r_state == S_DIR_RD) ? FLT_DIR : FLT_TAB;
                        n_state = S_FIN;
                    end else if (r_state == S_TAB_RD) begin
                        n_state = S_TAB_WB;
                    end else if (!ent_now[BIT_ACCESSED]) begin
                        n_state = S_DIR_WB;
                    end else if (tab_addr[31:PAB] != '0) begin
                        n_fault = FLT_RANGE;
                        n_state = S_FIN;
                    end else begin
                        n_base  = tab_addr[PAB-1:0];
                        n_state = S_TAB_RD;
                    end
                end
            end

            S_DIR_WB: begin
                n_cnt = 3'd0;
                if (tab_addr[31:PAB] != '0) begin
                    n_fault = FLT_RANGE;
                    n_state = S_FIN;
                end else begin
                    n_base  = tab_addr[PAB-1:0];
                    n_state = S_TAB_RD;
                end
            end

            S_TAB_WB: begin
                n_cnt = 3'd0;
                if (phys_addr[31:PAB] != '0) begin
                    n_fault = FLT_RANGE;
                    n_state = S_FIN;
                end else begin
                    n_base  = phys_addr[PAB-1:0];
                    n_state = S_DATA;
                end
            end

            S_DATA: begin
                n_cnt = r_cnt + 3'd1;
                if (!r_cmd && r_cnt != 3'd0) begin
                    n_rdata[{rpos, 3'b000} +: 8] = r_mem_q;
                end
                if (r_cnt == r_chunk) begin
                    n_cnt   = 3'd0;
                    n_done  = done_sum;
                    n_state = (done_sum == r_len) ? S_FIN : S_PART;
                end
            end

            S_FIN: begin
                n_valid      = 1'b1;
                n_read_data  = (r_cmd || r_fault != FLT_OK) ? 32'd0 : r_rdata;
                n_fault_code = r_fault;
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_va         <= n_va;
        r_len        <= n_len;
        r_wdata      <= n_wdata;
        r_done       <= n_done;
        r_chunk      <= n_chunk;
        r_cnt        <= n_cnt;
        r_cur        <= n_cur;
        r_ent        <= n_ent;
        r_base       <= n_base;
        r_rdata      <= n_rdata;
        r_fault      <= n_fault;
        r_read_data  <= n_read_data;
        r_fault_code <= n_fault_code;
    end

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg  <= 1'b0;
            r_pdb <= 32'd0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_PAGING_EN: r_pg  <= i_cfg_data[0];
                CFG_PAGE_DIR:  r_pdb <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // physical memory, single port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_addr];
    end

    // ---- assertions ----
    `TLPW_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `TLPW_ASSERT_IMPLY(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `TLPW_ASSERT_IMPLY(a_write_no_data, i_clk, i_rst_n, o_valid && r_cmd, o_read_data == 32'd0)
    `TLPW_ASSERT_IMPLY(a_we_states, i_clk, i_rst_n, mem_we,
        r_state == S_DIR_WB || r_state == S_TAB_WB || r_state == S_DATA)
    `TLPW_ASSERT_IMPLY(a_done_le_len, i_clk, i_rst_n, r_state != S_IDLE, r_done <= r_len)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for two_level_page_walk_mmu.
// Every command transfer is fed to a behavioral copy of the MMU: physical
// memory image, paging enable and directory base. That copy computes the
// reply the block must post. The monitor pops one reply per o_valid strobe.
// The run goes through these tests in turn:
//   - preload every byte of physical memory, so no read ever sees an
//     unwritten byte
//   - directed identity-mapped accesses
//   - build a small page table set, then directed page walks, including
//     faults and splits
//   - random traffic, mapped and unmapped, under several sender idle mixes

module tb;
    import tlpw_pkg::*;

    localparam int          PA_BITS   = PHYS_ADDR_BITS_DEF;
    localparam int          MEM_SIZE  = 1 << PA_BITS;
    localparam int          PAGE_SIZE = 1 << PAGE_OFF_BITS;
    localparam logic [31:0] OFF_MASK  = 32'h0000_0fff;
    localparam int          TAIL_CYC  = 40;          // > slowest split walk
    localparam longint      LIMIT_NS  = 25_000_000;  // watchdog

    // Page table layout built by the bench (all inside the 64 KiB image)
    localparam logic [31:0] DIR_PAGE  = 32'h0000_1000;
    localparam logic [31:0] TAB0_PAGE = 32'h0000_2000;
    localparam logic [31:0] TAB1_PAGE = 32'h0000_3000;

    // Config indexes the block does not decode; writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam bit ACC_RD = 1'b0;
    localparam bit ACC_WR = 1'b1;

    typedef struct packed {
        logic [31:0] rdata;
        t_fault      fault;
    } access_reply_t;

    // ---------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic                 i_cmd        = 1'b0;
    logic [31:0]          i_vaddr      = '0;
    logic [2:0]           i_access_len = '0;
    logic [31:0]          i_write_data = '0;
    logic                 o_valid;
    logic [31:0]          o_read_data;
    logic [1:0]           o_fault_code;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [31:0]          i_cfg_data   = '0;

    two_level_page_walk_mmu dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_vaddr      (i_vaddr),
        .i_access_len (i_access_len),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_fault_code (o_fault_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Behavioral MMU state
    // ---------------------------------------------------------------
    logic [7:0]    phys_image [0:MEM_SIZE-1];
    logic          model_paging   = 1'b0;
    logic [31:0]   model_dir_base = '0;
    access_reply_t access_replies [$];     // replies still owed by the DUT

    // Bookkeeping
    int  idle_pct        = 0;     // sender idle chance per transfer, percent
    int  gap_before_next = 0;     // idle cycles chosen at the last transfer
    bit  start_held      = 1'b0;  // start left high for a back-to-back transfer
    int  accesses_sent   = 0;
    int  walked_accesses = 0;
    int  replies_checked = 0;
    int  mismatch_count  = 0;
    int  fault_tally [4] = '{0, 0, 0, 0};

    // An entry or data part must lie wholly inside physical memory
    function automatic bit in_range(input logic [31:0] a, input int unsigned n);
        return (64'(a) + 64'(n)) <= 64'(MEM_SIZE);
    endfunction

    function automatic logic [31:0] load_entry(input logic [31:0] a);
        logic [31:0] v;
        logic [31:0] ea;
        for (int i = 0; i < 4; i++) begin
            ea = a + 32'(i);
            v[8*i +: 8] = phys_image[ea[PA_BITS-1:0]];
        end
        return v;
    endfunction

    function automatic void store_entry(input logic [31:0] a, input logic [31:0] v);
        logic [31:0] ea;
        for (int i = 0; i < 4; i++) begin
            ea = a + 32'(i);
            phys_image[ea[PA_BITS-1:0]] = v[8*i +: 8];
        end
    endfunction

    // Two-level walk with accessed/dirty write-backs
    function automatic t_fault walk_tables(input logic [31:0] va, input bit wr,
                                           output logic [31:0] pa);
        logic [31:0] dir_addr;
        logic [31:0] dir_ent;
        logic [31:0] tab_addr;
        logic [31:0] tab_ent;
        pa = va;
        dir_addr = (model_dir_base & ~OFF_MASK) + {20'd0, va[31:DIR_SHIFT], 2'b00};
        if (!in_range(dir_addr, 4)) return FLT_RANGE;
        dir_ent = load_entry(dir_addr);
        if (!dir_ent[BIT_PRESENT]) return FLT_DIR;
        // directory entry only goes back to memory when accessed was clear
        if (!dir_ent[BIT_ACCESSED]) begin
            dir_ent[BIT_ACCESSED] = 1'b1;
            store_entry(dir_addr, dir_ent);
        end
        tab_addr = (dir_ent & ~OFF_MASK)
                 + {20'd0, va[DIR_SHIFT-1:PAGE_OFF_BITS], 2'b00};
        if (!in_range(tab_addr, 4)) return FLT_RANGE;
        tab_ent = load_entry(tab_addr);
        if (!tab_ent[BIT_PRESENT]) return FLT_TAB;
        tab_ent[BIT_ACCESSED] = 1'b1;
        if (wr) tab_ent[BIT_DIRTY] = 1'b1;
        store_entry(tab_addr, tab_ent);
        pa = (tab_ent & ~OFF_MASK) + {20'd0, va[PAGE_OFF_BITS-1:0]};
        return FLT_OK;
    endfunction

    // One access: split at page boundaries, translate and perform each part.
    // Parts done before a fault stay done.
    function automatic access_reply_t model_access(input bit wr, input logic [31:0] va,
                                                   input logic [2:0] len_in,
                                                   input logic [31:0] wd);
        access_reply_t res;
        int unsigned   len;
        int unsigned   done;
        int unsigned   chunk;
        logic [31:0]   cur;
        logic [31:0]   pa;
        logic [31:0]   ea;
        t_fault        flt;
        len  = (len_in > MAX_LEN) ? MAX_LEN : len_in;   // saturate at four
        done = 0;
        flt  = FLT_OK;
        res.rdata = '0;
        while (done < len && flt == FLT_OK) begin
            cur   = va + 32'(done);                      // wraps modulo 2^32
            chunk = PAGE_SIZE - (cur & OFF_MASK);
            if (chunk > len - done) chunk = len - done;
            pa = cur;
            if (model_paging) flt = walk_tables(cur, wr, pa);
            if (flt == FLT_OK && !in_range(pa, chunk)) flt = FLT_RANGE;
            if (flt == FLT_OK) begin
                for (int i = 0; i < chunk; i++) begin
                    ea = pa + 32'(i);
                    if (wr) phys_image[ea[PA_BITS-1:0]] = wd[8*(done+i) +: 8];
                    else    res.rdata[8*(done+i) +: 8] = phys_image[ea[PA_BITS-1:0]];
                end
                done += chunk;
            end
        end
        if (wr || flt != FLT_OK) res.rdata = '0;
        res.fault = flt;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Reply monitor: o_valid is a one-cycle strobe, sampled at the edge
    // that ends the cycle it is on
    // ---------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR @%0t ns: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        access_reply_t want;
        if (i_rst_n && o_valid) begin
            if (access_replies.size() == 0) begin
                flag_mismatch($sformatf("reply with no access outstanding: rdata=%h fault=%0d",
                                        o_read_data, o_fault_code));
            end else begin
                want = access_replies.pop_front();
                replies_checked++;
                if (o_read_data !== want.rdata || o_fault_code !== want.fault)
                    flag_mismatch($sformatf("reply %0d: rdata exp %h got %h, fault exp %0d got %0d",
                                            replies_checked, want.rdata, o_read_data,
                                            want.fault, o_fault_code));
            end
        end
    end

    // ---------------------------------------------------------------
    // Command side. All tasks are entered and left at a rising edge.
    // start stays high across back-to-back transfers, so it never gets
    // two assignments in one time step.
    // ---------------------------------------------------------------
    task automatic send_access(input bit wr, input logic [31:0] va,
                               input logic [2:0] len, input logic [31:0] wd);
        if (!start_held) repeat (gap_before_next) @(posedge i_clk);
        start        <= 1'b1;
        i_cmd        <= wr;
        i_vaddr      <= va;
        i_access_len <= len;
        i_write_data <= wd;
        do @(posedge i_clk); while (busy);
        // transfer taken at this edge
        access_replies.push_back(model_access(wr, va, len, wd));
        fault_tally[access_replies[$].fault]++;
        accesses_sent++;
        if (model_paging) walked_accesses++;
        gap_before_next = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 24) : 0;
        start_held = (gap_before_next == 0);
        if (!start_held) start <= 1'b0;
    endtask

    task automatic stop_sending();
        if (start_held) begin
            start      <= 1'b0;
            start_held  = 1'b0;
        end
    endtask

    // Sender holds off until every owed reply has arrived
    task automatic drain_replies();
        stop_sending();
        while (access_replies.size() != 0) @(posedge i_clk);
    endtask

    // Config writes only with the block idle
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain_replies();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PAGING_EN: model_paging   = val[0];
            CFG_PAGE_DIR:  model_dir_base = val;
            default:       ;                            // undecoded index
        endcase
    endtask

    function automatic logic [31:0] va_of(input int d, input int t, input int off);
        return {10'(d), 10'(t), 12'(off)};
    endfunction

    // Mostly slots the bench maps (or marks absent), some fully random;
    // offsets lean to the page end so splits are common
    function automatic logic [31:0] pick_mapped_vaddr();
        int d;
        int t;
        int off;
        case ($urandom_range(5))
            0:       d = 0;
            1:       d = 1;
            2:       d = 2;
            3:       d = 3;
            4:       d = 512;
            default: d = 1023;
        endcase
        t = $urandom_range(9);
        if (t >= 8) t = t + 1014;                       // 1022, 1023
        if ($urandom_range(99) < 15) d = $urandom_range(1023);
        if ($urandom_range(99) < 15) t = $urandom_range(1023);
        off = ($urandom_range(99) < 30) ? 12'hffc + $urandom_range(3) : $urandom_range(4095);
        return va_of(d, t, off);
    endfunction

    function automatic logic [31:0] pick_phys_vaddr();
        int r;
        r = $urandom_range(99);
        if (r < 70) return {16'd0, 16'($urandom)};
        if (r < 94) return {16'd0, 4'($urandom), 12'hffc + 12'($urandom_range(3))};
        return $urandom;                                // mostly out of range
    endfunction

    // Idle mixes: flat out, sender idle 51%, then the receiver-stall mix,
    // which leaves the sender flat out since results cannot be held off,
    // and finally sender idle 7%
    function automatic int idle_plan(input int phase);
        case (phase)
            1:       return 51;
            3:       return 7;
            default: return 0;
        endcase
    endfunction

    task automatic run_random_accesses(input int count);
        logic [31:0] va;
        logic [2:0]  len;
        for (int i = 0; i < count; i++) begin
            idle_pct = idle_plan((i * 4) / count);
            va  = model_paging ? pick_mapped_vaddr() : pick_phys_vaddr();
            len = ($urandom_range(99) < 90) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7));
            send_access(1'($urandom_range(1)), va, len, $urandom);
        end
    endtask

    // Directory at DIR_PAGE; tables TAB0/TAB1 map to frames 4..15, entry 7 off memory
    task automatic build_page_tables();
        logic [31:0] tbl;
        int          idx;
        send_access(ACC_WR, DIR_PAGE + 4*0,    3'd4, TAB0_PAGE | 32'h001);
        send_access(ACC_WR, DIR_PAGE + 4*1,    3'd4, TAB1_PAGE | 32'h021); // accessed set
        send_access(ACC_WR, DIR_PAGE + 4*2,    3'd4, 32'h0040_0001);       // table off memory
        send_access(ACC_WR, DIR_PAGE + 4*3,    3'd4, TAB0_PAGE);           // absent
        send_access(ACC_WR, DIR_PAGE + 4*512,  3'd4, TAB0_PAGE | 32'h001);
        send_access(ACC_WR, DIR_PAGE + 4*1023, 3'd4, TAB1_PAGE | 32'h001);
        for (int k = 0; k < 2; k++) begin
            tbl = (k == 0) ? TAB0_PAGE : TAB1_PAGE;
            for (int j = 0; j < 8; j++) begin
                idx = (j < 6) ? j : j + 1016;
                send_access(ACC_WR, tbl + 32'(4*idx), 3'd4,
                            {20'($urandom_range(4, 15)), 12'($urandom) | 12'h001});
            end
            send_access(ACC_WR, tbl + 4*6, 3'd4, $urandom & ~32'h1);  // absent
            send_access(ACC_WR, tbl + 4*7, 3'd4, 32'h1234_5001);      // frame off memory
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_preload_memory();
        idle_pct = 0;
        for (int a = 0; a < MEM_SIZE; a += 4)
            send_access(ACC_WR, 32'(a), 3'd4, $urandom);
    endtask

    task automatic test_identity_access();
        idle_pct = 0;
        send_access(ACC_WR, 32'h0000_4000, 3'd4, 32'hffff_ffff);
        send_access(ACC_RD, 32'h0000_4000, 3'd4, 32'h0);
        send_access(ACC_WR, 32'h0000_4001, 3'd1, 32'h0);
        send_access(ACC_RD, 32'h0000_4000, 3'd2, 32'hffff_ffff);
        send_access(ACC_RD, 32'h0000_4000, 3'd3, 32'h0);
        send_access(ACC_RD, 32'h0000_4001, 3'd1, 32'h0);
        // zero length does nothing; lengths above four act as four
        send_access(ACC_WR, 32'h0000_4000, 3'd0, 32'h1234_5678);
        send_access(ACC_RD, 32'h0000_4000, 3'd0, 32'h0);
        send_access(ACC_WR, 32'h0000_4100, 3'd5, 32'hdead_beef);
        send_access(ACC_RD, 32'h0000_4100, 3'd7, 32'h0);
        // split across a page boundary
        send_access(ACC_WR, 32'h0000_4ffe, 3'd4, 32'ha5a5_5a5a);
        send_access(ACC_RD, 32'h0000_4ffd, 3'd4, 32'h0);
        // top of memory: first part lands, the second is out of range
        send_access(ACC_WR, 32'h0000_fffe, 3'd4, 32'h0bad_cafe);
        send_access(ACC_RD, 32'h0000_fffc, 3'd4, 32'h0);
        send_access(ACC_RD, 32'hffff_ffff, 3'd1, 32'h0);
        send_access(ACC_WR, 32'h0001_0000, 3'd2, 32'h0);
        send_access(ACC_RD, 32'h0000_0000, 3'd4, 32'h0);
        drain_replies();
    endtask

    task automatic test_page_walk();
        build_page_tables();
        write_config(CFG_PAGE_DIR, DIR_PAGE | 32'hfff);   // low bits ignored
        write_config(CFG_PAGING_EN, 32'h1);
        send_access(ACC_RD, va_of(0, 0, 12'h010), 3'd4, 32'h0);   // sets dir accessed
        send_access(ACC_WR, va_of(0, 0, 12'h010), 3'd4, 32'h7e57_0001); // dirty
        send_access(ACC_RD, va_of(1, 1, 12'h100), 3'd2, 32'h0);   // dir accessed preset
        send_access(ACC_RD, va_of(3, 0, 12'h000), 3'd4, 32'h0);   // directory absent
        send_access(ACC_WR, va_of(0, 6, 12'h000), 3'd4, 32'h0);   // table absent
        send_access(ACC_RD, va_of(0, 7, 12'h000), 3'd1, 32'h0);   // frame off memory
        send_access(ACC_RD, va_of(2, 0, 12'h000), 3'd1, 32'h0);   // table off memory
        // fault after progress: first page written, second page absent
        send_access(ACC_WR, va_of(0, 5, 12'hffe), 3'd4, 32'h1122_3344);
        send_access(ACC_RD, va_of(0, 5, 12'hffc), 3'd4, 32'h0);
        send_access(ACC_RD, va_of(0, 1, 12'hfff), 3'd4, 32'h0);   // split, both mapped
        // virtual wrap: the second part starts at address zero
        send_access(ACC_WR, 32'hffff_fffe, 3'd4, 32'hc0de_f00d);
        send_access(ACC_RD, 32'hffff_fffe, 3'd4, 32'h0);
        send_access(ACC_RD, va_of(512, 2, 12'h0), 3'd0, 32'h0);
        send_access(ACC_RD, va_of(512, 2, 12'h0), 3'd6, 32'h0);
        write_config(CFG_PAGE_DIR, 32'hffff_ffff);                // directory off memory
        send_access(ACC_RD, va_of(0, 0, 12'h0), 3'd4, 32'h0);
        write_config(CFG_PAGE_DIR, 32'h0);                        // directory in page 0
        send_access(ACC_RD, pick_mapped_vaddr(), 3'd4, 32'h0);
        // undecoded indexes must leave both registers alone
        write_config(CFG_PAGE_DIR, DIR_PAGE);
        write_config(CFG_SPARE_2, 32'h0);
        write_config(CFG_SPARE_3, $urandom);
        send_access(ACC_RD, va_of(1023, 1023, 12'h0), 3'd4, 32'h0);
        write_config(CFG_PAGING_EN, 32'h0);
    endtask

    task automatic test_random_identity();
        write_config(CFG_PAGING_EN, 32'h0);
        run_random_accesses(150);
        drain_replies();
    endtask

    function automatic logic [31:0] pick_dir_base();
        int r;
        r = $urandom_range(99);
        if (r < 70) return DIR_PAGE | 32'($urandom_range(4095));
        if (r < 80) return 32'h0;
        if (r < 90) return 32'hffff_ffff;
        return $urandom;
    endfunction

    task automatic test_random_paged();
        write_config(CFG_PAGING_EN, 32'h0);
        build_page_tables();   // identity traffic may have trashed them
        // Each block starts from a drained block (the pause until every
        // reply is in), with a fresh base and paging mode
        for (int blk = 0; blk < 9; blk++) begin
            write_config(CFG_PAGE_DIR, (blk == 0) ? DIR_PAGE : pick_dir_base());
            write_config(CFG_PAGING_EN, (blk == 0 || $urandom_range(99) < 85) ? 32'h1 : 32'h0);
            run_random_accesses(50);
        end
        write_config(CFG_PAGING_EN, 32'h0);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preload_memory();
        test_identity_access();
        test_page_walk();
        test_random_identity();
        test_random_paged();

        drain_replies();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (access_replies.size() != 0)
            flag_mismatch($sformatf("%0d replies never arrived", access_replies.size()));

        $display("Covered %0d accesses (%0d walked), %0d replies checked, %0d mismatches",
                 accesses_sent, walked_accesses, replies_checked, mismatch_count);
        $display("Faults: directory absent %0d, table absent %0d, out of range %0d",
                 fault_tally[FLT_DIR], fault_tally[FLT_TAB], fault_tally[FLT_RANGE]);
        if (mismatch_count == 0) begin
            $display("two_level_page_walk_mmu: match");
        end else begin
            $display("two_level_page_walk_mmu: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("Timeout with %0d replies outstanding", access_replies.size());
        $display("two_level_page_walk_mmu: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tlpw_pkg.sv
rtl/core/two_level_page_walk_mmu.sv
tb/sv/tb.sv
